### src/dead_zone_view_follow_top_defines.svh
// Assertion macros for the dead-zone view follow block.
`ifndef DEAD_ZONE_VIEW_FOLLOW_TOP_DEFINES_SVH
`define DEAD_ZONE_VIEW_FOLLOW_TOP_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define DZ_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication checked outside reset.
`define DZ_ASSERT_NXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

### src/dzvf_pkg.sv
// Package with types and constants of the dead-zone view follow block.
`timescale 1ns / 1ps
`default_nettype none
package dzvf_pkg;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam logic [29:0] KINV_Q30 = 30'd652032875;
    localparam logic [24:0] SPEED_BONUS = 25'd25600;
    localparam logic [23:0] SPEED_MAX = 24'hFFFFFF;
    localparam logic [23:0] DEF_SPEED_RST = 24'd192000;

    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_RADIUS = 3'd1;
    localparam logic [2:0] REG_OFF_X = 3'd2;
    localparam logic [2:0] REG_OFF_Y = 3'd3;
    localparam logic [2:0] REG_DEF_SPEED = 3'd4;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SNAP = 1'b1;

    typedef struct packed {
        logic               command;
        logic               target_present;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic               speed_valid;
        logic [23:0]        max_speed;
        logic [15:0]        delta_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic               chasing;
    } t_out_item;
endpackage
`default_nettype wire

### src/dzvf_cordic.sv
// Iterative CORDIC unit: vectoring then rotation, one micro-rotation a cycle.
`timescale 1ns / 1ps
`default_nettype none
module dzvf_cordic import dzvf_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire signed [32:0]  i_dx,
    input  wire signed [32:0]  i_dy,
    input  wire [23:0]         i_speed,
    output logic               o_done,
    output logic signed [24:0] o_vx,
    output logic signed [24:0] o_vy
);
    localparam int CW = $clog2(CORDIC_STEPS + 1);
    // Vectoring words: |dx| up to 2^32, growth under 2x, one extra bit margin.
    localparam int VW = 36;
    localparam int RW = 48;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_MUL = 5'b00010, S_VEC = 5'b00100,
        S_ROT = 5'b01000, S_FIN = 5'b10000
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_cnt;
    logic [CORDIC_STEPS-1:0] r_dirs;
    logic signed [VW-1:0] r_x, r_y;
    logic signed [RW-1:0] r_rx, r_ry;
    logic r_neg;
    logic [23:0] r_speed;
    logic [53:0] r_prod;
    logic [$clog2(CORDIC_STEPS)-1:0] w_i;
    logic signed [VW-1:0] w_xs, w_ys;
    logic signed [RW-1:0] w_rxs, w_rys, w_fx, w_fy;

    assign w_i = r_cnt[$clog2(CORDIC_STEPS)-1:0];
    assign w_xs = r_x >>> w_i;
    assign w_ys = r_y >>> w_i;
    assign w_rxs = r_rx >>> w_i;
    assign w_rys = r_ry >>> w_i;
    assign w_fx = (r_rx + RW'(8192)) >>> 14;
    assign w_fy = (r_ry + RW'(8192)) >>> 14;

    function automatic logic signed [24:0] clampv(input logic signed [RW-1:0] v,
                                                  input logic neg);
        logic signed [24:0] c;
        if (v > $signed(RW'(SPEED_MAX))) c = 25'sd16777215;
        else if (v < -$signed(RW'(SPEED_MAX))) c = -25'sd16777215;
        else c = v[24:0];
        return neg ? -c : c;
    endfunction

    // Sequencer: vectoring sweep, multiply, rotation sweep, final rounding.
    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_neg <= i_dx < 0;
                        r_x <= (i_dx < 0) ? -VW'(i_dx) : VW'(i_dx);
                        r_y <= (i_dx < 0) ? -VW'(i_dy) : VW'(i_dy);
                        r_speed <= i_speed;
                        r_cnt <= '0;
                        r_state <= S_VEC;
                    end
                end
                S_VEC: begin
                    r_dirs[w_i] <= r_y >= 0;
                    if (r_y >= 0) begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                    end else begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                    end
                    if (r_cnt == CW'(CORDIC_STEPS - 1)) begin
                        r_prod <= r_speed * KINV_Q30;
                        r_state <= S_MUL;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_MUL: begin
                    r_rx <= RW'(r_prod >> 16);
                    r_ry <= '0;
                    r_cnt <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (r_dirs[w_i]) begin
                        r_rx <= r_rx - w_rys;
                        r_ry <= r_ry + w_rxs;
                    end else begin
                        r_rx <= r_rx + w_rys;
                        r_ry <= r_ry - w_rxs;
                    end
                    if (r_cnt == CW'(CORDIC_STEPS - 1)) r_state <= S_FIN;
                    r_cnt <= r_cnt + 1'b1;
                end
                S_FIN: begin
                    o_vx <= clampv(w_fx, r_neg);
                    o_vy <= clampv(w_fy, r_neg);
                    o_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### src/dzvf_motion.sv
// Motion unit: one axis of center plus velocity times delta time, saturating.
`timescale 1ns / 1ps
`default_nettype none
module dzvf_motion import dzvf_pkg::*; (
    input  wire                i_clk,
    input  wire signed [31:0]  i_c,
    input  wire signed [24:0]  i_v,
    input  wire [15:0]         i_dt,
    output logic signed [31:0] o_c
);
    logic signed [41:0] r_prod;
    logic signed [31:0] r_c;
    logic signed [42:0] w_sum;

    // Stage one multiplies, stage two rounds, adds and saturates.
    always_ff @(posedge i_clk) begin
        r_prod <= i_v * $signed({1'b0, i_dt});
        r_c <= i_c;
    end
    assign w_sum = 43'(r_c) + 43'((r_prod + 42'sd2048) >>> 12);
    always_comb begin
        if (w_sum > 43'sd2147483647) o_c = 32'sh7FFFFFFF;
        else if (w_sum < -43'sd2147483648) o_c = 32'sh80000000;
        else o_c = w_sum[31:0];
    end
endmodule
`default_nettype wire

### src/dead_zone_view_follow_top.sv
// Dead-zone view follow: config registers, item sequencer, CORDIC and motion.
// Usage:
//   Input channel i_in_valid / o_in_stall carries one command item; output
//   channel o_out_valid / i_out_stall returns the center after that item.
//   Configuration is written through i_cfg_we, i_cfg_index, i_cfg_data
//   while the block is idle; unknown indexes are ignored.
// Sequence:
//   After the accepting edge a snap or a disabled tick passes S_TEST and
//   S_OUT; a tick without a direction update also passes S_MOVE, and a tick
//   that chases passes S_AIM before S_MOVE. The chase time is set by the
//   CORDIC unit doing one micro-rotation a cycle, first to find the
//   direction and then to rotate the speed vector. One item is in work at a
//   time; the next item can be taken in the cycle after its result is
//   registered.
// Reset:
//   i_rst_n low clears center, velocity and configuration to their reset
//   values and empties the result register.
// Stall:
//   While i_out_stall is high the result holds; a finished item waits for
//   the result register to free up before the block takes a new item.
`timescale 1ns / 1ps
`default_nettype none
`include "dead_zone_view_follow_top_defines.svh"
module dead_zone_view_follow_top import dzvf_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire t_in_item i_in_item,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_out_item  o_out_item,
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_index,
    input  wire [31:0] i_cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_TEST = 5'b00010, S_AIM = 5'b00100,
        S_MOVE = 5'b01000, S_OUT = 5'b10000
    } t_state;

    t_state r_state;
    logic r_enable;
    logic [30:0] r_radius;
    logic signed [31:0] r_off_x, r_off_y;
    logic [23:0] r_def_speed;
    logic signed [31:0] r_cx, r_cy;
    logic signed [24:0] r_vx, r_vy;
    t_in_item r_item;
    t_out_item r_out;
    logic r_mv;
    logic w_outside;
    logic w_cstart;
    logic w_cdone;
    logic w_out_load;
    logic signed [24:0] w_cvx, w_cvy;
    logic signed [31:0] w_ncx, w_ncy;
    logic signed [33:0] w_px, w_py;
    logic [24:0] w_bsum;
    logic [23:0] w_speed;
    logic w_accept;

    assign w_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = r_state != S_IDLE;

    // Dead zone test on the offset target point.
    assign w_px = 34'(r_item.target_x) + 34'(r_off_x) - 34'(r_cx);
    assign w_py = 34'(r_item.target_y) + 34'(r_off_y) - 34'(r_cy);
    assign w_bsum = {1'b0, r_item.max_speed} + SPEED_BONUS;
    assign w_speed = !r_item.speed_valid ? r_def_speed
                   : (w_bsum[24] ? SPEED_MAX : w_bsum[23:0]);
    // The direction is computed only for an enabled tick with a target outside.
    assign w_cstart = r_state == S_TEST && r_item.command == CMD_TICK && r_enable
                   && r_item.target_present && w_outside;

    always_comb begin
        w_outside = w_px < -$signed(34'(r_radius)) || w_px > $signed(34'(r_radius))
                 || w_py < -$signed(34'(r_radius)) || w_py > $signed(34'(r_radius));
    end

    dzvf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_cstart),
        .i_dx(33'(r_item.target_x) - 33'(r_cx)),
        .i_dy(33'(r_item.target_y) - 33'(r_cy)),
        .i_speed(w_speed), .o_done(w_cdone), .o_vx(w_cvx), .o_vy(w_cvy)
    );

    dzvf_motion u_mx (.i_clk(i_clk), .i_c(r_cx), .i_v(r_vx),
                      .i_dt(r_item.delta_time), .o_c(w_ncx));
    dzvf_motion u_my (.i_clk(i_clk), .i_c(r_cy), .i_v(r_vy),
                      .i_dt(r_item.delta_time), .o_c(w_ncy));

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_radius <= '0;
            r_off_x <= '0;
            r_off_y <= '0;
            r_def_speed <= DEF_SPEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ENABLE: r_enable <= i_cfg_data[0];
                REG_RADIUS: r_radius <= i_cfg_data[30:0];
                REG_OFF_X: r_off_x <= i_cfg_data;
                REG_OFF_Y: r_off_y <= i_cfg_data;
                REG_DEF_SPEED: r_def_speed <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // The result register loads when it is empty or being read out.
    assign w_out_load = r_state == S_OUT && (!o_out_valid || !i_out_stall);

    // Item sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_out_valid <= 1'b0;
            r_cx <= '0;
            r_cy <= '0;
            r_vx <= '0;
            r_vy <= '0;
            r_mv <= 1'b0;
        end else begin
            if (w_out_load) o_out_valid <= 1'b1;
            else if (!i_out_stall) o_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_item <= i_in_item;
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    r_mv <= 1'b0;
                    if (r_item.command == CMD_SNAP) begin
                        if (r_item.target_present) begin
                            r_cx <= r_item.target_x;
                            r_cy <= r_item.target_y;
                        end
                        r_state <= S_OUT;
                    end else if (!r_enable) begin
                        r_state <= S_OUT;
                    end else if (r_item.target_present && w_outside) begin
                        r_state <= S_AIM;
                    end else begin
                        if (r_item.target_present) begin
                            r_vx <= '0;
                            r_vy <= '0;
                        end
                        r_state <= S_MOVE;
                    end
                end
                S_AIM: begin
                    if (w_cdone) begin
                        r_vx <= w_cvx;
                        r_vy <= w_cvy;
                        r_mv <= 1'b0;
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    // Entry fills the multiply stage; with r_mv set, the sum is taken.
                    r_mv <= 1'b1;
                    if (r_mv) begin
                        r_cx <= w_ncx;
                        r_cy <= w_ncy;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out.center_x <= r_cx;
                        r_out.center_y <= r_cy;
                        r_out.chasing <= (r_vx != 0) || (r_vy != 0);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_item = r_out;

    `DZ_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall,
        "item accepted while busy")
    `DZ_ASSERT_NXT(a_out_after_seq, i_clk, i_rst_n, r_state == S_OUT, o_out_valid,
        "result not presented")
    `DZ_ASSERT_IMP(a_done_in_aim, i_clk, i_rst_n, w_cdone, r_state == S_AIM,
        "direction done outside aim")
endmodule
`default_nettype wire
